// ===== sv/frr_pkg.sv =====
// Package for the fraction reducer: microcode types, control word layout and program table.
package frr_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int STEP_W = 4;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIVINIT,
		OP_DIVSTEP,
		OP_GCDINIT,
		OP_GCDSTEP,
		OP_SAVE_NUM,
		OP_SAVE_DEN
	} op_t;

	typedef enum logic [2:0] {
		CND_NEVER,
		CND_ALWAYS,
		CND_NOT_IN,
		CND_B_ZERO,
		CND_CNT_MORE,
		CND_REM_ZERO,
		CND_Y_NZ,
		CND_OUT_BUSY
	} cond_t;

	typedef enum logic [1:0] {
		DS_A_B,
		DS_A_G,
		DS_B_G
	} dsel_t;

	typedef enum logic [1:0] {
		ST_FRAC = 2'd0,
		ST_INT  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic              emit;
		cond_t             cond;
		dsel_t             dsel;
		status_t           status;
		logic              ret;
		logic [STEP_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic b_zero;
		logic rem_zero;
		logic y_nz;
		logic cnt_more;
		logic out_busy;
	} flags_t;

	localparam logic [STEP_W-1:0] L_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] L_DIV1  = 4'd3;
	localparam logic [STEP_W-1:0] L_GCD   = 4'd6;
	localparam logic [STEP_W-1:0] L_DIV2  = 4'd8;
	localparam logic [STEP_W-1:0] L_DIV3  = 4'd11;
	localparam logic [STEP_W-1:0] L_EFRAC = 4'd13;
	localparam logic [STEP_W-1:0] L_EDIVZ = 4'd14;
	localparam logic [STEP_W-1:0] L_EINT  = 4'd15;

	function automatic ctl_t mk(op_t op, logic emit, cond_t cond, dsel_t dsel,
		status_t st, logic ret, logic [STEP_W-1:0] tgt);
		ctl_t c;
		c.op = op;
		c.emit = emit;
		c.cond = cond;
		c.dsel = dsel;
		c.status = st;
		c.ret = ret;
		c.target = tgt;
		return c;
	endfunction

	function automatic ctl_t ucode(logic [STEP_W-1:0] step);
		ctl_t c;
		case (step)
			4'd0:  c = mk(OP_LOAD,     1'b0, CND_NOT_IN,   DS_A_B, ST_FRAC, 1'b0, L_IDLE);
			4'd1:  c = mk(OP_NOP,      1'b0, CND_B_ZERO,   DS_A_B, ST_FRAC, 1'b0, L_EDIVZ);
			4'd2:  c = mk(OP_DIVINIT,  1'b0, CND_NEVER,    DS_A_B, ST_FRAC, 1'b0, L_IDLE);
			4'd3:  c = mk(OP_DIVSTEP,  1'b0, CND_CNT_MORE, DS_A_B, ST_FRAC, 1'b0, L_DIV1);
			4'd4:  c = mk(OP_NOP,      1'b0, CND_REM_ZERO, DS_A_B, ST_FRAC, 1'b0, L_EINT);
			4'd5:  c = mk(OP_GCDINIT,  1'b0, CND_NEVER,    DS_A_B, ST_FRAC, 1'b0, L_IDLE);
			4'd6:  c = mk(OP_GCDSTEP,  1'b0, CND_Y_NZ,     DS_A_B, ST_FRAC, 1'b0, L_GCD);
			4'd7:  c = mk(OP_DIVINIT,  1'b0, CND_NEVER,    DS_A_G, ST_FRAC, 1'b0, L_IDLE);
			4'd8:  c = mk(OP_DIVSTEP,  1'b0, CND_CNT_MORE, DS_A_G, ST_FRAC, 1'b0, L_DIV2);
			4'd9:  c = mk(OP_SAVE_NUM, 1'b0, CND_NEVER,    DS_A_B, ST_FRAC, 1'b0, L_IDLE);
			4'd10: c = mk(OP_DIVINIT,  1'b0, CND_NEVER,    DS_B_G, ST_FRAC, 1'b0, L_IDLE);
			4'd11: c = mk(OP_DIVSTEP,  1'b0, CND_CNT_MORE, DS_B_G, ST_FRAC, 1'b0, L_DIV3);
			4'd12: c = mk(OP_SAVE_DEN, 1'b0, CND_NEVER,    DS_A_B, ST_FRAC, 1'b0, L_IDLE);
			4'd13: c = mk(OP_NOP,      1'b1, CND_OUT_BUSY, DS_A_B, ST_FRAC, 1'b1, L_EFRAC);
			4'd14: c = mk(OP_NOP,      1'b1, CND_OUT_BUSY, DS_A_B, ST_DIVZ, 1'b1, L_EDIVZ);
			4'd15: c = mk(OP_NOP,      1'b1, CND_OUT_BUSY, DS_A_B, ST_INT,  1'b1, L_EINT);
			default: c = mk(OP_NOP,    1'b0, CND_ALWAYS,   DS_A_B, ST_FRAC, 1'b0, L_IDLE);
		endcase
		return c;
	endfunction

endpackage

// ===== sv/frr_sequencer.sv =====
// Microcode sequencer: step counter, program table lookup and conditional jumps.
module frr_sequencer
	import frr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  flags_t flags,
	output ctl_t   ctl
);

	logic [STEP_W-1:0] step_q;
	logic              take;

	always_comb begin
		ctl = ucode(step_q);
		case (ctl.cond)
			CND_NEVER:    take = 1'b0;
			CND_ALWAYS:   take = 1'b1;
			CND_NOT_IN:   take = !in_valid;
			CND_B_ZERO:   take = flags.b_zero;
			CND_CNT_MORE: take = flags.cnt_more;
			CND_REM_ZERO: take = flags.rem_zero;
			CND_Y_NZ:     take = flags.y_nz;
			CND_OUT_BUSY: take = flags.out_busy;
			default:      take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= L_IDLE;
		end else if (take) begin
			step_q <= ctl.target;
		end else if (ctl.ret) begin
			step_q <= L_IDLE;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

endmodule

// ===== sv/frr_datapath.sv =====
// Datapath: operand registers, restoring divider, binary GCD unit and output register.
module frr_datapath
	import frr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_t                  ctl,
	input  logic                  in_valid,
	input  logic [DATA_WIDTH-1:0] in_num,
	input  logic [DATA_WIDTH-1:0] in_den,
	input  logic                  out_ready,
	output flags_t                flags,
	output logic                  out_valid,
	output status_t               out_status,
	output logic                  out_neg,
	output logic [DATA_WIDTH-1:0] out_quot,
	output logic [DATA_WIDTH-1:0] out_rnum,
	output logic [DATA_WIDTH-1:0] out_rden
);

	localparam int DW = DATA_WIDTH;
	localparam int CW = $clog2(DW + 1);
	localparam int KW = $clog2(DW);

	logic [DW-1:0] a_q, b_q, rem_q, quo_q, dvs_q, x_q, y_q;
	logic [KW-1:0] k_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic          valid_q;

	logic [DW-1:0] g;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          busy;
	logic          do_emit;

	assign g     = x_q << k_q;
	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign busy  = valid_q && !out_ready;
	assign do_emit = ctl.emit && !busy;

	assign flags.b_zero   = (b_q == '0);
	assign flags.rem_zero = (rem_q == '0);
	assign flags.y_nz     = (y_q != '0);
	assign flags.cnt_more = (cnt_q != CW'(1));
	assign flags.out_busy = busy;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: begin
				if (in_valid) begin
					a_q   <= in_num[DW-1] ? DW'(~in_num + 1'b1) : in_num;
					b_q   <= in_den[DW-1] ? DW'(~in_den + 1'b1) : in_den;
					neg_q <= in_num[DW-1] ^ in_den[DW-1];
				end
			end
			OP_DIVINIT: begin
				rem_q <= '0;
				cnt_q <= CW'(DW);
				case (ctl.dsel)
					DS_A_B: begin
						quo_q <= a_q;
						dvs_q <= b_q;
					end
					DS_A_G: begin
						quo_q <= a_q;
						dvs_q <= g;
					end
					DS_B_G: begin
						quo_q <= b_q;
						dvs_q <= g;
					end
					default: begin
						quo_q <= a_q;
						dvs_q <= b_q;
					end
				endcase
			end
			OP_DIVSTEP: begin
				cnt_q <= cnt_q - 1'b1;
				if (!diff[DW]) begin
					rem_q <= diff[DW-1:0];
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= trial[DW-1:0];
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
			end
			OP_GCDINIT: begin
				a_q <= rem_q;
				x_q <= b_q;
				y_q <= rem_q;
				k_q <= '0;
			end
			OP_GCDSTEP: begin
				if (y_q != '0) begin
					if (!x_q[0] && !y_q[0]) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + 1'b1;
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_q > y_q) begin
						x_q <= y_q;
						y_q <= x_q - y_q;
					end else begin
						y_q <= y_q - x_q;
					end
				end
			end
			OP_SAVE_NUM: a_q <= quo_q;
			OP_SAVE_DEN: b_q <= quo_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (do_emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_emit) begin
			out_status <= ctl.status;
			out_neg    <= neg_q;
			out_quot   <= (ctl.status == ST_INT) ? quo_q : '0;
			out_rnum   <= a_q;
			out_rden   <= b_q;
		end
	end

	assign out_valid = valid_q;

endmodule

// ===== sv/fraction_reducer_unit.sv =====
// Top level of the fraction reducer: stream ports around the sequencer and the datapath.
//
//  channel | dir | tdata fields (low bit up)                        | tuser
//  s_*     | in  | numerator, denominator                           | -
//  m_*     | out | negative, quotient, reduced_num, reduced_den     | status
//
// A zero denominator goes straight to its emit step. Otherwise the numerator is
// divided by the denominator and an exact integer is emitted; a proper fraction adds
// the binary GCD loop and two divisions by the GCD, one quotient bit per cycle.
// Reset clears the step counter and the output valid; no clearing pass.
// A result waiting on m_tready holds the sequencer at its emit step only.
module fraction_reducer_unit
	import frr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int SW = ((2 * DATA_WIDTH + 7) / 8) * 8,
	localparam int MW = ((3 * DATA_WIDTH + 1 + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [SW-1:0] s_tdata,   // numerator, denominator, zero pad
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [MW-1:0] m_tdata,   // negative, quotient, reduced_numerator,
	                                 // reduced_denominator, zero pad
	output logic [1:0]    m_tuser    // status
);

	localparam int DW = DATA_WIDTH;

	ctl_t          ctl;
	flags_t        flags;
	status_t       st;
	logic          neg;
	logic [DW-1:0] quot, rnum, rden;

	frr_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.flags    (flags),
		.ctl      (ctl)
	);

	frr_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.in_valid   (s_tvalid),
		.in_num     (s_tdata[DW-1:0]),
		.in_den     (s_tdata[2*DW-1:DW]),
		.out_ready  (m_tready),
		.flags      (flags),
		.out_valid  (m_tvalid),
		.out_status (st),
		.out_neg    (neg),
		.out_quot   (quot),
		.out_rnum   (rnum),
		.out_rden   (rden)
	);

	assign s_tready = (ctl.op == OP_LOAD);
	assign m_tuser  = st;
	assign m_tdata  = MW'({rden, rnum, quot, neg});

endmodule

// ===== sv/frr_checker.sv =====
// Port-level checker for the fraction reducer, bound to the top level.
module frr_checker
	import frr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int MW = ((3 * DATA_WIDTH + 1 + 7) / 8) * 8
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [MW-1:0] m_tdata,
	input logic [1:0]    m_tuser
);

	localparam int DW = DATA_WIDTH;

	logic [DW-1:0] quot, rnum, rden;

	assign quot = m_tdata[DW:1];
	assign rnum = m_tdata[2*DW:DW+1];
	assign rden = m_tdata[3*DW:2*DW+1];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while one is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == ST_FRAC || m_tuser == ST_INT || m_tuser == ST_DIVZ)
		else $error("undefined status code");

	a_divz_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_DIVZ |-> quot == '0 && rden == '0)
		else $error("divide-by-zero result fields wrong");

	a_frac_proper: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FRAC |-> quot == '0 && rnum != '0 && rnum < rden)
		else $error("reduced fraction is not proper");

endmodule

bind fraction_reducer_unit frr_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_frr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
